@@ sv/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    `ASSERT_IMPL(label, clk, rst_n, (a) |=> (b), msg)
`endif

@@ sv/hcs_pkg.sv @@
package hcs_pkg;
    localparam int NUM_BINS = 256;
    localparam int CNT_W = 21;
    localparam int MAX_PIXELS = 1048576;
    localparam logic [CNT_W-1:0] BIN_LIMIT =
        (MAX_PIXELS < (1 << CNT_W) - 1) ? CNT_W'(MAX_PIXELS) : {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_COUNT = 2'd1,
        CMD_MAP   = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_CNT_RD,
        ST_CNT_WAIT,
        ST_CNT_WR,
        ST_SCAN,
        ST_SCAN_END,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clr_en;       // write zero at sweep address, advance
        logic sweep_start;  // reset sweep address
        logic cnt_rd;       // read bin of latched pixel
        logic cnt_wr;       // write incremented bin
        logic scan_rd;      // read at sweep address, advance
        logic scan_start;   // clear bound registers
        logic div_start;
        logic out_load;
        logic latch_in;
    } t_cmd_bus;

    typedef struct packed {
        logic sweep_done;
        logic scan_done;
        logic div_done;
    } t_status;
endpackage

@@ sv/hcs_ram.sv @@
module hcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/hcs_ctrl.sv @@
module hcs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [1:0]       i_command,
    input  logic             i_cfg_write,
    input  logic             i_out_busy,
    input  hcs_pkg::t_status i_status,
    output logic             o_stall,
    output hcs_pkg::t_cmd_bus o_cmd
);
    hcs_pkg::t_state r_state, n_state;
    logic r_current, n_current;
    logic acc;

    assign acc = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hcs_pkg::ST_INIT;
            r_current <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_current <= n_current;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_current = r_current;
        if (i_cfg_write) begin
            n_current = 1'b0;
        end
        case (r_state)
            hcs_pkg::ST_INIT: begin
                if (i_status.sweep_done) n_state = hcs_pkg::ST_IDLE;
            end
            hcs_pkg::ST_IDLE: begin
                if (acc) begin
                    case (hcs_pkg::t_cmd'(i_command))
                        hcs_pkg::CMD_CLEAR: begin
                            n_state = hcs_pkg::ST_CLEAR;
                            n_current = 1'b0;
                        end
                        hcs_pkg::CMD_COUNT: begin
                            n_state = hcs_pkg::ST_CNT_RD;
                            n_current = 1'b0;
                        end
                        hcs_pkg::CMD_MAP: begin
                            n_state = r_current ? hcs_pkg::ST_SCAN_END : hcs_pkg::ST_SCAN;
                        end
                        default: n_state = hcs_pkg::ST_IDLE;
                    endcase
                end
            end
            hcs_pkg::ST_CLEAR: begin
                if (i_status.sweep_done) n_state = hcs_pkg::ST_IDLE;
            end
            hcs_pkg::ST_CNT_RD:   n_state = hcs_pkg::ST_CNT_WAIT;
            hcs_pkg::ST_CNT_WAIT: n_state = hcs_pkg::ST_CNT_WR;
            hcs_pkg::ST_CNT_WR:   n_state = hcs_pkg::ST_IDLE;
            hcs_pkg::ST_SCAN: begin
                if (i_status.sweep_done) n_state = hcs_pkg::ST_SCAN_END;
            end
            hcs_pkg::ST_SCAN_END: begin
                if (i_status.scan_done) begin
                    n_state = hcs_pkg::ST_DIV;
                    n_current = 1'b1;
                end
            end
            hcs_pkg::ST_DIV: begin
                if (i_status.div_done) n_state = hcs_pkg::ST_OUT;
            end
            hcs_pkg::ST_OUT: begin
                if (!i_out_busy) n_state = hcs_pkg::ST_IDLE;
            end
            default: n_state = hcs_pkg::ST_INIT;
        endcase
    end

    always_comb begin
        o_stall = (r_state != hcs_pkg::ST_IDLE);
        o_cmd = '0;
        o_cmd.latch_in = acc;
        case (r_state)
            hcs_pkg::ST_INIT:  o_cmd.clr_en = 1'b1;
            hcs_pkg::ST_IDLE: begin
                o_cmd.sweep_start = 1'b1;
            end
            hcs_pkg::ST_CLEAR:    o_cmd.clr_en = 1'b1;
            hcs_pkg::ST_CNT_RD:   o_cmd.cnt_rd = 1'b1;
            hcs_pkg::ST_CNT_WR:   o_cmd.cnt_wr = 1'b1;
            hcs_pkg::ST_SCAN:     o_cmd.scan_rd = 1'b1;
            hcs_pkg::ST_SCAN_END: o_cmd.div_start = i_status.scan_done;
            hcs_pkg::ST_DIV:      o_cmd.out_load = i_status.div_done;
            default: ;
        endcase
        if (r_state == hcs_pkg::ST_IDLE && acc && !r_current &&
            i_command == hcs_pkg::CMD_MAP) begin
            o_cmd.scan_start = 1'b1;
        end
    end
endmodule

@@ sv/hcs_datapath.sv @@
module hcs_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hcs_pkg::t_cmd_bus i_cmd,
    input  logic [7:0]        i_pixel,
    input  logic [20:0]       i_min_count,
    input  logic              i_out_stall,
    output hcs_pkg::t_status  o_status,
    output logic              o_out_busy,
    output logic              o_valid,
    output logic [7:0]        o_stretched_pixel,
    output logic [8:0]        o_low_level,
    output logic signed [8:0] o_high_level
);
    logic [7:0]  r_pix;
    logic [8:0]  r_addr;
    logic [7:0]  r_rd_idx;
    logic        r_rd_vld;
    logic [8:0]  r_lo;
    logic [8:0]  r_hi;
    logic [20:0] rdata;
    logic        we;
    logic [7:0]  waddr, raddr;
    logic [20:0] wdata;
    logic [17:0] r_rem;
    logic [8:0]  r_q;
    logic [17:0] r_div;
    logic [4:0]  r_step;
    logic        r_busy;
    logic [7:0]  r_res;
    logic        r_done;
    logic        r_valid;
    logic [7:0]  r_o_pix;
    logic [8:0]  r_o_lo, r_o_hi;
    logic [8:0]  span;
    logic [8:0]  offset;
    logic        below, above;
    logic [17:0] r_num;
    logic [17:0] trial_in;

    assign we    = i_cmd.clr_en || i_cmd.cnt_wr;
    assign waddr = i_cmd.cnt_wr ? r_pix : r_addr[7:0];
    assign wdata = i_cmd.cnt_wr ? ((rdata < hcs_pkg::BIN_LIMIT) ? rdata + 21'd1 : rdata)
                                : '0;
    assign raddr = i_cmd.scan_rd ? r_addr[7:0] : r_pix;

    hcs_ram #(.WIDTH(hcs_pkg::CNT_W), .DEPTH(hcs_pkg::NUM_BINS)) u_bins (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_status.sweep_done = (r_addr[7:0] == 8'hFF) && (i_cmd.clr_en || i_cmd.scan_rd);
    assign o_status.scan_done  = !r_rd_vld;
    assign o_status.div_done   = r_done;

    assign below  = ({1'b0, r_pix} < r_lo);
    assign above  = $signed({1'b0, r_pix}) > $signed(r_hi);
    assign span   = r_hi - r_lo;
    assign offset = {1'b0, r_pix} - r_lo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) r_pix <= i_pixel;
        if (!i_rst_n || i_cmd.sweep_start) begin
            r_addr <= '0;
        end else if (i_cmd.clr_en || i_cmd.scan_rd) begin
            r_addr <= r_addr + 9'd1;
        end
        r_rd_idx <= r_addr[7:0];
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
        end
        if (!i_rst_n) begin
            r_lo <= 9'd256;
            r_hi <= 9'h1FF;
        end else if (i_cmd.scan_start) begin
            if (!i_cmd.div_start) begin
                r_lo <= 9'd256;
                r_hi <= 9'h1FF;
            end
        end else if (r_rd_vld && rdata > i_min_count) begin
            if (r_lo == 9'd256) r_lo <= {1'b0, r_rd_idx};
            r_hi <= {1'b0, r_rd_idx};
        end
    end

    // Restoring division of (510*d + span) by 2*span, one quotient bit a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.div_start) begin
                if (below) begin
                    r_res  <= 8'd0;
                    r_done <= 1'b1;
                end else if (above) begin
                    r_res  <= 8'd255;
                    r_done <= 1'b1;
                end else if (span == 9'd0) begin
                    r_res  <= 8'd0;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_step <= 5'd0;
                    r_rem  <= '0;
                    r_div  <= {8'd0, span, 1'b0};
                    r_q    <= '0;
                    r_res  <= '0;
                end
            end else if (r_busy) begin
                r_step <= r_step + 5'd1;
                if (trial_in >= r_div) begin
                    r_rem <= trial_in - r_div;
                    r_q   <= {r_q[7:0], 1'b1};
                end else begin
                    r_rem <= trial_in;
                    r_q   <= {r_q[7:0], 1'b0};
                end
                if (r_step == 5'd17) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= (trial_in >= r_div) ? {r_q[6:0], 1'b1} : {r_q[6:0], 1'b0};
                end
            end
        end
    end

    assign trial_in = {r_rem[16:0], r_num[5'd17 - r_step]};
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_num <= 18'(18'(offset) * 18'd510) + 18'(span);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_o_pix <= r_res;
            r_o_lo  <= r_lo;
            r_o_hi  <= r_hi;
        end
    end

    assign o_out_busy        = r_valid;
    assign o_valid           = r_valid;
    assign o_stretched_pixel = r_o_pix;
    assign o_low_level       = r_o_lo;
    assign o_high_level      = $signed(r_o_hi);
endmodule

@@ sv/histogram_contrast_stretch_unit.sv @@
// Channel | Direction | Signals
// in      | input     | i_valid, o_stall, i_command, i_pixel
// out     | output    | o_valid, i_stall, o_stretched_pixel, o_low_level, o_high_level
// cfg     | input     | i_cfg_valid, o_cfg_ready, i_cfg_data (min_count)
// After reset a clearing pass over the 256 bins runs with the input stalled.
// Clear writes zero to every bin, and count is a read-modify-write of the pixel's bin.
// A map with current bounds runs the serial divider, or skips it when the pixel lies
// outside the bounds or the bounds are equal; a map without them scans the bins first.
// After a map the next transfer is taken once the result has left the output register.
module histogram_contrast_stretch_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_command,
    input  logic [7:0]        i_pixel,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_stretched_pixel,
    output logic [8:0]        o_low_level,
    output logic signed [8:0] o_high_level,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [20:0]       i_cfg_data
);
    logic [20:0]       r_min_count;
    hcs_pkg::t_cmd_bus cmd;
    hcs_pkg::t_status  status;
    logic              out_busy;
    logic              cfg_write;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_count <= '0;
        end else if (cfg_write) begin
            r_min_count <= i_cfg_data;
        end
    end

    hcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_command   (i_command),
        .i_cfg_write (cfg_write),
        .i_out_busy  (out_busy),
        .i_status    (status),
        .o_stall     (o_stall),
        .o_cmd       (cmd)
    );

    hcs_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_pixel           (i_pixel),
        .i_min_count       (r_min_count),
        .i_out_stall       (i_stall),
        .o_status          (status),
        .o_out_busy        (out_busy),
        .o_valid           (o_valid),
        .o_stretched_pixel (o_stretched_pixel),
        .o_low_level       (o_low_level),
        .o_high_level      (o_high_level)
    );
endmodule

@@ sv/hcs_checker.sv @@
`include "assert_macros.svh"
module hcs_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [7:0]        o_stretched_pixel,
    input logic [8:0]        o_low_level,
    input logic signed [8:0] o_high_level
);
    logic held;
    logic no_bounds;
    logic has_bounds;
    logic pix_zero;
    logic bounds_ordered;

    assign held           = o_valid && i_stall;
    assign no_bounds      = o_valid && (o_low_level == 9'd256);
    assign has_bounds     = o_valid && (o_low_level != 9'd256);
    assign pix_zero       = (o_stretched_pixel == 8'd0);
    assign bounds_ordered = (o_high_level >= $signed(o_low_level));

    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, held, o_valid && $stable(o_stretched_pixel), "result dropped")
    `ASSERT_IMPL(a_busy, i_clk, i_rst_n, o_valid |-> o_stall, "input taken while result pending")
    `ASSERT_IMPL(a_none, i_clk, i_rst_n, no_bounds |-> pix_zero, "no bounds must map to zero")
    `ASSERT_IMPL(a_order, i_clk, i_rst_n, has_bounds |-> bounds_ordered, "bounds out of order")
endmodule

bind histogram_contrast_stretch_unit hcs_checker u_hcs_checker (.*);
